>>> sv/apg_pkg.sv
// Package for the arc point generator: shared widths, constants and types.
// Used by every module of the block; depends on nothing.
package apg_pkg;
	localparam int SEG_W = 6;
	localparam int SWEEP_W = 17;
	localparam int OUT_W = 16;
	localparam int ANG_W = 25;
	localparam int DEF_MAX_SEGMENTS = 63;
	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_OUT_FRAC_BITS = 15;
	localparam int SWEEP_LIMIT = 46080;
	// Quarter and full turn in 1/32768 degree.
	localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * 32768);
	localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(360 * 32768);
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	// Quotient width: |sweep*256| fits in 24 bits plus sign.
	localparam int NUM_W = 25;

	// Arctangent of 2^-i in degrees, scaled by 2^22.
	function automatic logic signed [31:0] atan_deg_q22(input logic [4:0] i);
		logic signed [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'sd188743680;
				5'd1: r = 32'sd111421900;
				5'd2: r = 32'sd58872272;
				5'd3: r = 32'sd29884485;
				5'd4: r = 32'sd15000234;
				5'd5: r = 32'sd7507429;
				5'd6: r = 32'sd3754631;
				5'd7: r = 32'sd1877430;
				5'd8: r = 32'sd938729;
				5'd9: r = 32'sd469366;
				5'd10: r = 32'sd234683;
				5'd11: r = 32'sd117342;
				5'd12: r = 32'sd58671;
				5'd13: r = 32'sd29335;
				5'd14: r = 32'sd14668;
				5'd15: r = 32'sd7334;
				5'd16: r = 32'sd3667;
				5'd17: r = 32'sd1833;
				5'd18: r = 32'sd917;
				5'd19: r = 32'sd458;
				5'd20: r = 32'sd229;
				5'd21: r = 32'sd115;
				5'd22: r = 32'sd57;
				5'd23: r = 32'sd29;
				default: r = 32'sd0;
			endcase
			return r;
		end
	endfunction

	// Tag that travels with each angle through the CORDIC pipeline.
	typedef struct packed {
		logic [SEG_W-1:0] idx;
		logic fin;
		logic [1:0] quad;
	} apg_tag_t;
endpackage

>>> sv/arc_point_generator.sv
// Arc point generator: a request of n segments gives n+1 points, none if n is zero.
// The points follow a division, one per cycle unless the output stalls.
// A new request is taken only after the last point of the previous one has been issued.
// The CORDIC pipeline takes one angle per cycle unless stalled, one stage per iteration.
// Reset (arst_n low, asynchronous) clears the sequencer and all valid bits.
module arc_point_generator
	import apg_pkg::*;
#(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [SEG_W-1:0] segments,
	input  logic signed [SWEEP_W-1:0] sweep_deg,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [OUT_W-1:0] cos_x,
	output logic signed [OUT_W-1:0] sin_y,
	output logic [SEG_W-1:0] point_index,
	output logic last
);
	logic a_valid, a_stall;
	logic [ANG_W-1:0] a_ang;
	apg_tag_t a_tag, o_tag;

	// Sequencer issues angles into the CORDIC pipeline.
	apg_seq #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_seq (
		.clk, .arst_n, .in_valid, .in_stall, .segments, .sweep_deg,
		.a_valid, .a_stall, .a_ang, .a_tag
	);

	apg_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_cordic (
		.clk, .arst_n, .i_valid(a_valid), .i_stall(a_stall), .i_ang(a_ang), .i_tag(a_tag),
		.o_valid(out_valid), .o_stall(out_stall), .o_cos(cos_x), .o_sin(sin_y), .o_tag
	);

	assign point_index = o_tag.idx;
	assign last = o_tag.fin;
endmodule

>>> sv/apg_seq.sv
// Arc sequencer: clamps the request, divides the sweep by the segment count
// one quotient bit per cycle, then issues one reduced angle per point. Uses apg_pkg.
module apg_seq
	import apg_pkg::*;
#(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [SEG_W-1:0] segments,
	input  logic signed [SWEEP_W-1:0] sweep_deg,
	output logic a_valid,
	input  logic a_stall,
	output logic [ANG_W-1:0] a_ang,
	output apg_tag_t a_tag
);
	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

	localparam int CNT_W = $clog2(NUM_W + 1);

	state_t state_q;
	logic [SEG_W-1:0] num_q;
	logic [SEG_W-1:0] idx_q;
	logic neg_q;
	logic [NUM_W-1:0] dividend_q;
	logic [NUM_W-1:0] quot_q;
	logic [SEG_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [ANG_W-1:0] step_q;
	logic signed [ANG_W-1:0] cur_q;
	logic signed [ANG_W-1:0] end_q;

	logic signed [SWEEP_W-1:0] sw_c;
	logic [SEG_W-1:0] num_c;
	logic signed [ANG_W-1:0] sw256_c;
	logic [SEG_W:0] trial_c;
	logic [NUM_W-1:0] quot_n;
	logic fin_c;
	logic signed [ANG_W-1:0] ang_c;
	logic signed [ANG_W:0] mod1_c;
	logic [ANG_W-1:0] m_c;

	// Clamp of the request fields.
	always_comb begin
		if (sweep_deg > SWEEP_W'(SWEEP_LIMIT))
			sw_c = SWEEP_W'(SWEEP_LIMIT);
		else if (sweep_deg < -SWEEP_W'(SWEEP_LIMIT))
			sw_c = -SWEEP_W'(SWEEP_LIMIT);
		else
			sw_c = sweep_deg;
		num_c = (segments > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : segments;
		sw256_c = ANG_W'(sw_c) <<< 8;
	end

	// One restoring division step on the magnitude.
	always_comb begin
		trial_c = {rem_q, dividend_q[NUM_W-1]};
		quot_n = {quot_q[NUM_W-2:0], (trial_c >= {1'b0, num_q})};
	end

	// Angle of the current point, reduced into [0, 360) degrees and split by quadrant.
	always_comb begin
		fin_c = (idx_q == num_q);
		ang_c = fin_c ? end_q : cur_q;
		if (ang_c < 0)
			mod1_c = (ANG_W+1)'(ang_c) + (ANG_W+1)'(FULL_TURN);
		else
			mod1_c = (ANG_W+1)'(ang_c);
		if (mod1_c >= (ANG_W+1)'(FULL_TURN))
			m_c = ANG_W'(mod1_c - (ANG_W+1)'(FULL_TURN));
		else
			m_c = ANG_W'(mod1_c);
		if (m_c >= ANG_W'(3) * QUARTER_TURN) begin
			a_tag.quad = 2'd3;
			a_ang = m_c - ANG_W'(3) * QUARTER_TURN;
		end else if (m_c >= ANG_W'(2) * QUARTER_TURN) begin
			a_tag.quad = 2'd2;
			a_ang = m_c - ANG_W'(2) * QUARTER_TURN;
		end else if (m_c >= QUARTER_TURN) begin
			a_tag.quad = 2'd1;
			a_ang = m_c - QUARTER_TURN;
		end else begin
			a_tag.quad = 2'd0;
			a_ang = m_c;
		end
		a_tag.idx = idx_q;
		a_tag.fin = fin_c;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign a_valid = (state_q == ST_EMIT);

	// Sequencer state and arc registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && num_c != '0) begin
						state_q <= ST_DIV;
						num_q <= num_c;
						neg_q <= sw256_c < 0;
						dividend_q <= (sw256_c < 0) ? NUM_W'(-sw256_c) : NUM_W'(sw256_c);
						end_q <= sw256_c;
						rem_q <= '0;
						quot_q <= '0;
						cnt_q <= '0;
						idx_q <= '0;
						cur_q <= '0;
					end
				end
				ST_DIV: begin
					if (trial_c >= {1'b0, num_q})
						rem_q <= SEG_W'(trial_c - {1'b0, num_q});
					else
						rem_q <= SEG_W'(trial_c);
					dividend_q <= {dividend_q[NUM_W-2:0], 1'b0};
					quot_q <= quot_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= ST_EMIT;
						step_q <= neg_q ? -$signed(quot_n) : $signed(quot_n);
					end
				end
				ST_EMIT: begin
					if (!a_stall) begin
						cur_q <= cur_q + step_q;
						idx_q <= idx_q + 1'b1;
						if (fin_c)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		a_valid |-> idx_q <= num_q) else $error("point index beyond segment count");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		a_valid |-> in_stall) else $error("request taken while emitting");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		a_valid && !a_stall && fin_c |=> !a_valid) else $error("emit past last point");
`endif
endmodule

>>> sv/apg_cordic.sv
// Rotation-mode CORDIC pipeline in degrees, one iteration per stage, with
// quadrant fix-up, rounding and saturation at the end. Uses apg_pkg.
module apg_cordic
	import apg_pkg::*;
#(
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic i_valid,
	output logic i_stall,
	input  logic [ANG_W-1:0] i_ang,
	input  apg_tag_t i_tag,
	output logic o_valid,
	input  logic o_stall,
	output logic signed [OUT_W-1:0] o_cos,
	output logic signed [OUT_W-1:0] o_sin,
	output apg_tag_t o_tag
);
	localparam int N = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam int SH = 30 - OUT_FRAC_BITS;

	logic adv;
	logic [N:0] v_s;
	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic signed [33:0] z_s [0:N];
	apg_tag_t t_s [0:N];
	logic signed [33:0] c_r, s_r, rc, rs;

	// The pipe moves as one; the output register holds under stall.
	assign adv = !(o_valid && o_stall);
	assign i_stall = !adv;

	// Stage 0 loads the start vector and the residual angle in 2^-22 degree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (adv)
			v_s[0] <= i_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= CORDIC_GAIN_Q30;
			y_s[0] <= '0;
			z_s[0] <= 34'(i_ang) <<< 7;
			t_s[0] <= i_tag;
		end
	end

	// One micro-rotation per register stage.
	for (genvar g = 0; g < N; g++) begin : g_it
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[g+1] <= 1'b0;
			else if (adv)
				v_s[g+1] <= v_s[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				t_s[g+1] <= t_s[g];
				if (!z_s[g][33]) begin
					x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] - 34'(atan_deg_q22(5'(g)));
				end else begin
					x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] + 34'(atan_deg_q22(5'(g)));
				end
			end
		end
	end

	// Rounding, quadrant signs and saturation.
	always_comb begin
		c_r = (x_s[N] + (34'sd1 <<< (SH - 1))) >>> SH;
		s_r = (y_s[N] + (34'sd1 <<< (SH - 1))) >>> SH;
		unique case (t_s[N].quad)
			2'd0: begin rc = c_r; rs = s_r; end
			2'd1: begin rc = -s_r; rs = c_r; end
			2'd2: begin rc = -c_r; rs = -s_r; end
			default: begin rc = s_r; rs = -c_r; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_valid <= 1'b0;
		else if (adv)
			o_valid <= v_s[N];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			o_cos <= (rc > 34'sd32767) ? 16'sh7FFF : (rc < -34'sd32768) ? 16'sh8000 : 16'(rc);
			o_sin <= (rs > 34'sd32767) ? 16'sh7FFF : (rs < -34'sd32768) ? 16'sh8000 : 16'(rs);
			o_tag <= t_s[N];
		end
	end

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_stall |=> o_valid) else $error("result lost under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		i_stall |-> o_valid) else $error("stall without pending result");
	a_z_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> !z_s[0][33]) else $error("negative reduced angle");
`endif
endmodule

>>> test/arc_point_generator_tb.sv
// Testbench for the arc point generator: directed and random arc requests.
// Depends on apg_pkg and arc_point_generator; predicts each point with a CORDIC model.
`timescale 1ns / 100ps

module arc_point_generator_tb;
	import apg_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic signed [OUT_W-1:0] cos_v;
		logic signed [OUT_W-1:0] sin_v;
		logic [SEG_W-1:0] idx;
		logic fin;
	} arc_point_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [SEG_W-1:0] segments;
	logic signed [SWEEP_W-1:0] sweep_deg;
	logic out_valid;
	logic out_stall;
	logic signed [OUT_W-1:0] cos_x;
	logic signed [OUT_W-1:0] sin_y;
	logic [SEG_W-1:0] point_index;
	logic last;

	arc_point_t expected_points[$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit gaps_on = 1;
	bit hold_off = 0;

	arc_point_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.segments(segments), .sweep_deg(sweep_deg),
		.out_valid(out_valid), .out_stall(out_stall),
		.cos_x(cos_x), .sin_y(sin_y), .point_index(point_index), .last(last)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Floor division by a power of two.
	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic longint arctan_q22(int i);
		longint tbl[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
			3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
			3667, 1833, 917, 458, 229, 115, 57, 29};
		return tbl[i];
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return OUT_W'(v);
	endfunction

	// Cosine and sine of an angle in 1/32768 degree, quadrant reduced.
	task automatic unit_vector(input longint ang, output logic signed [OUT_W-1:0] c_o,
			output logic signed [OUT_W-1:0] s_o);
		longint full_t;
		longint quarter_t;
		longint m, q, x, y, z, xn, c, s;
		full_t = 360 * 32768;
		quarter_t = 90 * 32768;
		m = ang % full_t;
		if (m < 0)
			m += full_t;
		q = m / quarter_t;
		z = (m - q * quarter_t) * 128;
		x = 652032874;
		y = 0;
		for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				xn = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= arctan_q22(i);
			end else begin
				xn = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += arctan_q22(i);
			end
			x = xn;
		end
		c = floor_shift(x + (1 << 14), 15);
		s = floor_shift(y + (1 << 14), 15);
		case (q)
			0: begin c_o = clamp16(c); s_o = clamp16(s); end
			1: begin c_o = clamp16(-s); s_o = clamp16(c); end
			2: begin c_o = clamp16(-c); s_o = clamp16(-s); end
			default: begin c_o = clamp16(s); s_o = clamp16(-c); end
		endcase
	endtask

	// Queue up the points that one arc request produces.
	task automatic predict_arc(input logic [SEG_W-1:0] seg_in, input logic signed [SWEEP_W-1:0] sw_in);
		longint sw, step, ang;
		int n;
		arc_point_t p;
		sw = sw_in;
		if (sw > SWEEP_LIMIT)
			sw = SWEEP_LIMIT;
		if (sw < -SWEEP_LIMIT)
			sw = -SWEEP_LIMIT;
		n = seg_in;
		if (n > DEF_MAX_SEGMENTS)
			n = DEF_MAX_SEGMENTS;
		if (n == 0)
			return;
		step = (sw * 256) / n;
		ang = 0;
		for (int i = 0; i <= n; i++) begin
			unit_vector((i == n) ? sw * 256 : ang, p.cos_v, p.sin_v);
			p.idx = SEG_W'(i);
			p.fin = (i == n);
			expected_points.insert(expected_points.size(), p);
			ang += step;
		end
	endtask

	// Send one request, with optional random gaps before it. Valid stays high
	// after the accepting edge only until the next request or gap is driven.
	task automatic send_arc(input logic [SEG_W-1:0] seg_in, input logic signed [SWEEP_W-1:0] sw_in);
		while (gaps_on && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		segments <= seg_in;
		sweep_deg <= sw_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_arc(seg_in, sw_in);
	endtask

	function automatic logic signed [SWEEP_W-1:0] random_sweep();
		case ($urandom_range(9))
			0: return SWEEP_W'($urandom);
			1: return SWEEP_W'($urandom_range(4) * 11520);
			2: return -SWEEP_W'($urandom_range(4) * 11520);
			default: return SWEEP_W'(int'($urandom_range(2 * SWEEP_LIMIT)) - SWEEP_LIMIT);
		endcase
	endfunction

	// Receiver stall: random, forced high during the hold-off.
	always @(posedge clk) begin
		out_stall <= hold_off || (gaps_on && $urandom_range(99) < 18);
	end

	// Compare each accepted point against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point idx %0d cos %0d sin %0d", $time, point_index,
					cos_x, sin_y);
				fail_count++;
			end else begin
				arc_point_t e;
				e = expected_points.pop_front();
				if (cos_x !== e.cos_v || sin_y !== e.sin_v || point_index !== e.idx
						|| last !== e.fin) begin
					$display("%0t: mismatch expected cos %0d sin %0d idx %0d last %0d",
						$time, e.cos_v, e.sin_v, e.idx, e.fin);
					$display("%0t:          actual   cos %0d sin %0d idx %0d last %0d",
						$time, cos_x, sin_y, point_index, last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Extremes of both fields, zero segments, and angles on quadrant edges.
	task automatic test_directed();
		send_arc(6'd1, 17'sd0);
		send_arc(6'd0, 17'sd11520);
		send_arc(6'd63, 17'sd46080);
		send_arc(6'd63, -17'sd46080);
		send_arc(6'd1, 17'sd65535);
		send_arc(6'd1, SWEEP_W'(-65536));
		send_arc(6'd4, 17'sd46080);
		send_arc(6'd4, -17'sd46080);
		send_arc(6'd2, 17'sd23040);
		send_arc(6'd3, 17'sd1);
		send_arc(6'd3, -17'sd1);
		send_arc(6'd7, 17'sd12345);
		send_arc(6'd42, -17'sd33333);
		send_arc(6'd0, -17'sd1);
	endtask

	// Receiver holds off while requests keep coming.
	task automatic test_backpressure();
		hold_off = 1;
		fork
			begin
				repeat (3) send_arc(6'd63, random_sweep());
			end
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
		join
	endtask

	task automatic test_random(input int count);
		logic [SEG_W-1:0] seg;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0)
				seg = SEG_W'($urandom);
			else
				seg = SEG_W'($urandom_range(1, 8));
			send_arc(seg, random_sweep());
		end
	endtask

	task automatic wait_for_drain();
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		segments = '0;
		sweep_deg = '0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(140);
		// A stretch with no idling on either side.
		gaps_on = 0;
		test_random(60);
		gaps_on = 1;
		test_random(90);
		in_valid <= 1'b0;
		wait_for_drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
